[rtl/ile_pkg.sv]
package ile_pkg;

   // Operation codes carried in the opcode field of a request beat.
   typedef enum logic [2:0] {
      OP_APPEND     = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_INSERT_AT  = 3'd2,
      OP_REPLACE_AT = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_POP_BACK   = 3'd5,
      OP_REMOVE_AT  = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // How the entry row moves in one operation.
   typedef enum logic [2:0] {
      MODE_HOLD,
      MODE_SET,
      MODE_SHIFT_UP,
      MODE_SHIFT_DOWN,
      MODE_CLEAR
   } mode_type;

   typedef struct packed {
      status_type status;
      mode_type   mode;
      logic       rd_en;
   } ctrl_type;

   // Field layout of the stream beats.
   localparam int OPCODE_W   = 3;
   localparam int POSITION_W = 4;
   localparam int ITEM_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int READ_W     = 32;
   localparam int COUNT_W    = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

endpackage

[rtl/ile_decode.sv]
module ile_decode #(
   parameter int CAPACITY = 16
) (
   input  ile_pkg::op_type                     opcode,
   input  logic [ile_pkg::POSITION_W-1:0]      position,
   input  logic [$clog2(CAPACITY+1)-1:0]       count,
   output ile_pkg::ctrl_type                   ctrl,
   output logic [$clog2(CAPACITY+1)-1:0]       idx,
   output logic [$clog2(CAPACITY+1)-1:0]       count_next
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > ile_pkg::POSITION_W) ? CNT_W : ile_pkg::POSITION_W;

   logic [CMP_W-1:0] pos_wide;
   logic             in_range;
   logic             full;
   logic             empty;

   assign pos_wide = CMP_W'(position);
   assign in_range = pos_wide < CMP_W'(count);
   assign full     = count >= CNT_W'(CAPACITY);
   assign empty    = count == '0;

   always_comb begin
      ctrl.status = ile_pkg::ST_OK;
      ctrl.mode   = ile_pkg::MODE_HOLD;
      ctrl.rd_en  = 1'b0;
      idx         = pos_wide[CNT_W-1:0];
      count_next  = count;
      unique case (opcode)
         ile_pkg::OP_APPEND: begin
            idx = count;
            if (full) begin
               ctrl.status = ile_pkg::ST_FULL;
            end else begin
               ctrl.mode  = ile_pkg::MODE_SET;
               count_next = count + CNT_W'(1);
            end
         end
         ile_pkg::OP_PUSH_FRONT: begin
            idx = '0;
            if (full) begin
               ctrl.status = ile_pkg::ST_FULL;
            end else begin
               ctrl.mode  = ile_pkg::MODE_SHIFT_UP;
               count_next = count + CNT_W'(1);
            end
         end
         ile_pkg::OP_INSERT_AT: begin
            priority if (!in_range) begin
               ctrl.status = ile_pkg::ST_RANGE;
            end else if (full) begin
               ctrl.status = ile_pkg::ST_FULL;
            end else begin
               ctrl.mode  = ile_pkg::MODE_SHIFT_UP;
               count_next = count + CNT_W'(1);
            end
         end
         ile_pkg::OP_REPLACE_AT: begin
            if (!in_range) begin
               ctrl.status = ile_pkg::ST_RANGE;
            end else begin
               ctrl.mode = ile_pkg::MODE_SET;
            end
         end
         ile_pkg::OP_READ_AT: begin
            if (!in_range) begin
               ctrl.status = ile_pkg::ST_RANGE;
            end else begin
               ctrl.rd_en = 1'b1;
            end
         end
         ile_pkg::OP_POP_BACK: begin
            // Popping is a remove of the last entry; an empty list is left alone.
            idx = count - CNT_W'(1);
            if (!empty) begin
               ctrl.mode  = ile_pkg::MODE_SHIFT_DOWN;
               ctrl.rd_en = 1'b1;
               count_next = count - CNT_W'(1);
            end
         end
         ile_pkg::OP_REMOVE_AT: begin
            if (!in_range) begin
               ctrl.status = ile_pkg::ST_RANGE;
            end else begin
               ctrl.mode  = ile_pkg::MODE_SHIFT_DOWN;
               ctrl.rd_en = 1'b1;
               count_next = count - CNT_W'(1);
            end
         end
         ile_pkg::OP_CLEAR: begin
            ctrl.mode  = ile_pkg::MODE_CLEAR;
            count_next = '0;
         end
      endcase
   end

endmodule

[rtl/ile_store.sv]
module ile_store #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  ile_pkg::mode_type                 mode,
   input  logic [$clog2(CAPACITY+1)-1:0]     idx,
   input  logic [DATA_WIDTH-1:0]             word,
   output logic [DATA_WIDTH-1:0]             rd_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] entry_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] entry_in [CAPACITY];

   // Each entry picks its next value from itself, a neighbor, the new word or zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
      localparam logic [CNT_W-1:0] SLOT = CNT_W'(i);
      logic [DATA_WIDTH-1:0] below;
      logic [DATA_WIDTH-1:0] above;

      if (i == 0) begin : g_first
         assign below = '0;
      end else begin : g_lower
         assign below = entry_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign above = '0;
      end else begin : g_upper
         assign above = entry_ff[i+1];
      end

      always_comb begin
         entry_in[i] = entry_ff[i];
         unique case (mode)
            ile_pkg::MODE_HOLD: begin
               entry_in[i] = entry_ff[i];
            end
            ile_pkg::MODE_SET: begin
               if (SLOT == idx) entry_in[i] = word;
            end
            ile_pkg::MODE_SHIFT_UP: begin
               if (SLOT == idx) begin
                  entry_in[i] = word;
               end else if (SLOT > idx) begin
                  entry_in[i] = below;
               end
            end
            ile_pkg::MODE_SHIFT_DOWN: begin
               if (SLOT >= idx) entry_in[i] = above;
            end
            ile_pkg::MODE_CLEAR: begin
               entry_in[i] = '0;
            end
            default: begin
               entry_in[i] = entry_ff[i];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            entry_ff[i] <= '0;
         end else if (update) begin
            entry_ff[i] <= entry_in[i];
         end
      end
   end

   always_comb begin
      rd_data = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         if (CNT_W'(j) == idx) rd_data = entry_ff[j];
      end
   end

endmodule

[rtl/indexed_list_engine_core.sv]
// Indexed list engine: an ordered list of up to CAPACITY data words that takes
// one operation per request beat (append, push to front, insert, replace, read,
// pop from back, remove, clear) and answers every request with exactly one
// response beat carrying a status, the word read, popped or removed (zero
// otherwise) and the entry count after the operation. A request is registered;
// once the response register can take a beat, the operation is decoded and
// applied to the entry row while its response is written into an output
// register. One request is taken in every cycle as long as the response side
// keeps taking beats, since every entry picks its next value from itself, its
// neighbors, the new word or zero in a single update. Reset clears the list at
// once. Stored words are DATA_WIDTH bits wide; incoming words are cut to that
// width and read words are zero extended to the 32-bit field.
module indexed_list_engine_core #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: opcode (3), position (4), item_value (32), zero pad (1).
   input  logic [ile_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0 up: status (2), read_value (32), entry_count (5), zero pad (1).
   output logic [ile_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Request register.
   logic                                in_valid_ff;
   logic                                in_valid_in;
   ile_pkg::op_type                     in_op_ff;
   logic [ile_pkg::POSITION_W-1:0]      in_pos_ff;
   logic [ile_pkg::ITEM_W-1:0]          in_word_ff;

   // Response register.
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   ile_pkg::status_type                 rsp_status_ff;
   logic [ile_pkg::READ_W-1:0]          rsp_read_ff;
   logic [ile_pkg::READ_W-1:0]          rsp_read_in;
   logic [ile_pkg::COUNT_W-1:0]         rsp_count_ff;

   // List state.
   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;

   ile_pkg::ctrl_type                   ctrl;
   logic [CNT_W-1:0]                    idx;
   logic [DATA_WIDTH-1:0]               store_word;
   logic [DATA_WIDTH-1:0]               rd_data;
   logic                                advance;
   logic                                req_take;

   // The registered request moves on when the response register is empty or
   // is being emptied in this cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   assign store_word  = DATA_WIDTH'(64'(in_word_ff));
   assign rsp_read_in = ctrl.rd_en ? ile_pkg::READ_W'(64'(rd_data)) : '0;

   ile_decode #(
      .CAPACITY   (CAPACITY)
   ) u_decode (
      .opcode     (in_op_ff),
      .position   (in_pos_ff),
      .count      (count_ff),
      .ctrl       (ctrl),
      .idx        (idx),
      .count_next (count_in)
   );

   ile_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .update     (advance),
      .mode       (ctrl.mode),
      .idx        (idx),
      .word       (store_word),
      .rd_data    (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) count_ff <= count_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= ile_pkg::op_type'(req_tdata[ile_pkg::OPCODE_W-1:0]);
         in_pos_ff  <= req_tdata[ile_pkg::OPCODE_W +: ile_pkg::POSITION_W];
         in_word_ff <= req_tdata[ile_pkg::OPCODE_W + ile_pkg::POSITION_W +: ile_pkg::ITEM_W];
      end
      if (advance) begin
         rsp_status_ff <= ctrl.status;
         rsp_read_ff   <= rsp_read_in;
         rsp_count_ff  <= ile_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_read_ff, rsp_status_ff};

endmodule

[rtl/ile_checker.sv]
module ile_checker #(
   parameter int CAPACITY = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [ile_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic [1:0]  status;
   logic [31:0] read_value;
   logic [4:0]  entry_count;

   assign status      = rsp_tdata[1:0];
   assign read_value  = rsp_tdata[33:2];
   assign entry_count = rsp_tdata[38:34];

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Only the three defined status codes are ever reported.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (status <= ile_pkg::ST_FULL))
      else $error("undefined status code");

   // A failed operation returns no data word.
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status != ile_pkg::ST_OK) |-> (read_value == 32'd0))
      else $error("data returned with a failing status");

   // A full report only comes while the list holds its whole capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == ile_pkg::ST_FULL) |-> (entry_count == 5'(CAPACITY)))
      else $error("full status with a list below capacity");

   // A stalled response beat is held.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response beat changed while stalled");

endmodule

bind indexed_list_engine_core ile_checker #(
   .CAPACITY   (CAPACITY)
) u_ile_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/tb_top.sv]
// Self-checking bench for the indexed list engine core. A directed table walks
// the list through its corner cases (empty list, list full, out-of-range
// indexes, clear), then a long random run drives well-formed grow and shrink
// phases with random words. Every accepted request beat goes through a
// behavioral list model kept here, and each response beat is compared field by
// field with the oldest expected response.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH    = 16;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int CYCLE_LIMIT   = 400000;
   // Settling time after the last response, before the run ends.
   localparam int SETTLE_CYCLES = 8;

   // One response beat, as the list model expects it.
   typedef struct packed {
      ile_pkg::status_type status;
      logic [31:0]         read_value;
      logic [4:0]          entry_count;
   } list_result_type;

   // One row of the directed table. A row may be repeated; each repeat adds
   // the repeat index to the data word. Rows marked known carry a response
   // that can be read off the list rules directly.
   typedef struct packed {
      ile_pkg::op_type op;
      logic [3:0]      pos;
      logic [31:0]     word;
      logic [4:0]      reps;
      logic            known;
      list_result_type result;
   } plan_row_type;

   localparam int PLAN_ROWS = 25;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [ile_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [ile_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Behavioral copy of the list: the words and the number of valid entries.
   logic [31:0]  list_words [LIST_DEPTH];
   int unsigned  list_len;

   list_result_type awaited_responses [$];
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   bit           random_phase;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      // Empty list: pop gives zero with ok, every indexed operation is rejected.
      '{ile_pkg::OP_POP_BACK,   4'd0,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_READ_AT,    4'd0,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_RANGE, 32'h0, 5'd0}},
      // Insert at the count itself is never allowed.
      '{ile_pkg::OP_INSERT_AT,  4'd0,  32'h1234_5678, 5'd1,  1'b1,
        '{ile_pkg::ST_RANGE, 32'h0, 5'd0}},
      '{ile_pkg::OP_REPLACE_AT, 4'd15, 32'hFFFF_FFFF, 5'd1,  1'b1,
        '{ile_pkg::ST_RANGE, 32'h0, 5'd0}},
      '{ile_pkg::OP_REMOVE_AT,  4'd0,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_RANGE, 32'h0, 5'd0}},
      '{ile_pkg::OP_APPEND,     4'd0,  32'hFFFF_FFFF, 5'd1,  1'b1,
        '{ile_pkg::ST_OK,    32'h0, 5'd1}},
      '{ile_pkg::OP_READ_AT,    4'd0,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_OK, 32'hFFFF_FFFF, 5'd1}},
      '{ile_pkg::OP_PUSH_FRONT, 4'd0,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_OK,    32'h0, 5'd2}},
      '{ile_pkg::OP_INSERT_AT,  4'd1,  32'hA5A5_A5A5, 5'd1,  1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_INSERT_AT,  4'd3,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_RANGE, 32'h0, 5'd3}},
      '{ile_pkg::OP_REPLACE_AT, 4'd2,  32'h5A5A_5A5A, 5'd1,  1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_READ_AT,    4'd1,  32'h0,         5'd1,  1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_REMOVE_AT,  4'd0,  32'h0,         5'd1,  1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_CLEAR,      4'd0,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_READ_AT,    4'd0,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_RANGE, 32'h0, 5'd0}},
      // Fill to capacity, then every growing operation must report full.
      '{ile_pkg::OP_APPEND,     4'd0,  32'h8000_0000, 5'd16, 1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_APPEND,     4'd0,  32'h1111_1111, 5'd1,  1'b1,
        '{ile_pkg::ST_FULL,  32'h0, 5'd16}},
      '{ile_pkg::OP_PUSH_FRONT, 4'd0,  32'h2222_2222, 5'd1,  1'b1,
        '{ile_pkg::ST_FULL,  32'h0, 5'd16}},
      '{ile_pkg::OP_INSERT_AT,  4'd15, 32'h3333_3333, 5'd1,  1'b1,
        '{ile_pkg::ST_FULL,  32'h0, 5'd16}},
      '{ile_pkg::OP_READ_AT,    4'd15, 32'h0,         5'd1,  1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_REPLACE_AT, 4'd15, 32'h0,         5'd1,  1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_REMOVE_AT,  4'd0,  32'h0,         5'd1,  1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_REMOVE_AT,  4'd15, 32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_RANGE, 32'h0, 5'd15}},
      '{ile_pkg::OP_POP_BACK,   4'd0,  32'h0,         5'd2,  1'b0,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}},
      '{ile_pkg::OP_CLEAR,      4'd0,  32'h0,         5'd1,  1'b1,
        '{ile_pkg::ST_OK,    32'h0, 5'd0}}
   };

   indexed_list_engine_core #(
      .CAPACITY   (LIST_DEPTH),
      .DATA_WIDTH (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Applies one operation to the local list and returns the response it gives.
   // The index check comes before the full check, so an insert at a bad index
   // reports out of range even on a full list.
   function automatic list_result_type apply_list_op(input ile_pkg::op_type op,
                                                     input logic [3:0] pos,
                                                     input logic [31:0] word);
      list_result_type res;
      int i;
      bit in_range;
      bit is_full;
      res = '{ile_pkg::ST_OK, 32'h0, 5'd0};
      in_range = pos < list_len;
      is_full = list_len >= LIST_DEPTH;
      case (op)
         ile_pkg::OP_APPEND: begin
            if (is_full) begin
               res.status = ile_pkg::ST_FULL;
            end else begin
               list_words[list_len] = word;
               list_len++;
            end
         end
         ile_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               res.status = ile_pkg::ST_FULL;
            end else begin
               for (i = int'(list_len); i > 0; i--) list_words[i] = list_words[i-1];
               list_words[0] = word;
               list_len++;
            end
         end
         ile_pkg::OP_INSERT_AT: begin
            if (!in_range) begin
               res.status = ile_pkg::ST_RANGE;
            end else if (is_full) begin
               res.status = ile_pkg::ST_FULL;
            end else begin
               for (i = int'(list_len); i > int'(pos); i--) list_words[i] = list_words[i-1];
               list_words[pos] = word;
               list_len++;
            end
         end
         ile_pkg::OP_REPLACE_AT: begin
            if (!in_range) res.status = ile_pkg::ST_RANGE;
            else list_words[pos] = word;
         end
         ile_pkg::OP_READ_AT: begin
            if (!in_range) res.status = ile_pkg::ST_RANGE;
            else res.read_value = list_words[pos];
         end
         ile_pkg::OP_POP_BACK: begin
            // Popping an empty list is not an error; it just returns zero.
            if (list_len > 0) begin
               list_len--;
               res.read_value = list_words[list_len];
               list_words[list_len] = 32'h0;
            end
         end
         ile_pkg::OP_REMOVE_AT: begin
            if (!in_range) begin
               res.status = ile_pkg::ST_RANGE;
            end else begin
               res.read_value = list_words[pos];
               for (i = int'(pos); i + 1 < int'(list_len); i++) list_words[i] = list_words[i+1];
               list_len--;
               list_words[list_len] = 32'h0;
            end
         end
         default: begin
            for (i = 0; i < LIST_DEPTH; i++) list_words[i] = 32'h0;
            list_len = 0;
         end
      endcase
      res.entry_count = list_len[4:0];
      return res;
   endfunction

   // Offers one request beat, starting at a falling edge, and holds it until the
   // block takes it. The model is updated at the accepting edge and the task
   // returns at the next falling edge, so the caller can either offer the next
   // beat right away or drop valid for a gap.
   task automatic send_request(input ile_pkg::op_type op, input logic [3:0] pos,
                               input logic [31:0] word, input bit use_known,
                               input list_result_type known_result);
      list_result_type predicted;
      req_tdata  <= {1'b0, word, pos, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_op(op, pos, word);
      awaited_responses.push_back(use_known ? known_result : predicted);
      @(negedge clock);
   endtask

   // Picks a random operation. Most of the run alternates between a growing
   // phase and a shrinking phase so that both the full and the empty list are
   // reached often; indexes are mostly inside the list, sometimes anywhere.
   task automatic send_random_request(inout bit growing);
      ile_pkg::op_type op;
      logic [3:0]      pos;
      logic [31:0]     word;
      int unsigned     pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         op = ile_pkg::OP_CLEAR;
      end else if (growing) begin
         if (pick < 40) op = ile_pkg::OP_APPEND;
         else if (pick < 55) op = ile_pkg::OP_PUSH_FRONT;
         else if (pick < 75) op = ile_pkg::OP_INSERT_AT;
         else if (pick < 84) op = ile_pkg::OP_REPLACE_AT;
         else if (pick < 92) op = ile_pkg::OP_READ_AT;
         else if (pick < 96) op = ile_pkg::OP_POP_BACK;
         else op = ile_pkg::OP_REMOVE_AT;
      end else begin
         if (pick < 35) op = ile_pkg::OP_REMOVE_AT;
         else if (pick < 60) op = ile_pkg::OP_POP_BACK;
         else if (pick < 74) op = ile_pkg::OP_READ_AT;
         else if (pick < 84) op = ile_pkg::OP_REPLACE_AT;
         else if (pick < 90) op = ile_pkg::OP_APPEND;
         else if (pick < 95) op = ile_pkg::OP_PUSH_FRONT;
         else op = ile_pkg::OP_INSERT_AT;
      end
      if (list_len > 0 && $urandom_range(0, 9) != 0) pos = 4'($urandom_range(0, list_len - 1));
      else pos = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 15))
         0: word = 32'h0;
         1: word = 32'hFFFF_FFFF;
         default: word = $urandom;
      endcase
      send_request(op, pos, word, 1'b0, '0);
      // Turn around once the list is empty, sometimes once it is full, and now and then at random.
      if (list_len == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 49) == 0) growing = !growing;
   endtask

   // Main stimulus: reset, the directed table, then bursts of random beats.
   initial begin
      int unsigned sent;
      int unsigned burst;
      int unsigned row;
      int unsigned rep;
      bit growing;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      random_phase = 1'b0;
      growing      = 1'b1;
      list_len     = 0;
      for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = 32'h0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < PLAN_ROWS; row++) begin
         for (rep = 0; rep < directed_plan[row].reps; rep++) begin
            send_request(directed_plan[row].op, directed_plan[row].pos,
                         directed_plan[row].word + rep, directed_plan[row].known,
                         directed_plan[row].result);
         end
      end

      // Let every directed response drain before the random part starts.
      req_tvalid <= 1'b0;
      while (awaited_responses.size() != 0) @(negedge clock);
      random_phase = 1'b1;

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            send_random_request(growing);
            sent++;
         end
         // A quarter of the bursts run straight into the next one without a gap.
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            if ($urandom_range(0, 39) == 0) begin
               while (awaited_responses.size() != 0) @(negedge clock);
            end else begin
               repeat ($urandom_range(1, 8)) @(negedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Response side back-pressure. It runs in segments: fully ready, random
   // stalls at a random duty, or a steady stall. Once the random part starts it
   // holds off for a long stretch so the block fills up and has to stall its
   // request side while the sender keeps offering beats.
   initial begin
      int unsigned span;
      int unsigned duty;
      bit long_hold_done;
      rsp_tready     = 1'b0;
      long_hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (random_phase && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat ($urandom_range(60, 90)) @(negedge clock);
         end else begin
            case ($urandom_range(0, 15))
               0: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(10, 40)) @(negedge clock);
               end
               1, 2, 3, 4, 5: begin
                  rsp_tready <= 1'b1;
                  repeat ($urandom_range(5, 40)) @(negedge clock);
               end
               default: begin
                  span = $urandom_range(10, 50);
                  duty = $urandom_range(20, 90);
                  for (int c = 0; c < span; c++) begin
                     rsp_tready <= ($urandom_range(0, 99) < duty);
                     @(negedge clock);
                  end
               end
            endcase
         end
      end
   end

   // Response checker: every beat taken must match the oldest expectation.
   always @(posedge clock) begin
      list_result_type want;
      logic [1:0]   got_status;
      logic [31:0]  got_read;
      logic [4:0]   got_count;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = rsp_tdata[1:0];
         got_read   = rsp_tdata[33:2];
         got_count  = rsp_tdata[38:34];
         if (awaited_responses.size() == 0) begin
            $error("response beat with nothing expected: status %0d, read_value %h, count %0d",
                   got_status, got_read, got_count);
            error_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (got_status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, got_status);
               error_count++;
            end
            if (got_read !== want.read_value) begin
               $error("read_value mismatch: expected %h, got %h", want.read_value, got_read);
               error_count++;
            end
            if (got_count !== want.entry_count) begin
               $error("entry_count mismatch: expected %0d, got %0d",
                      want.entry_count, got_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog. The run fails once the cycle limit is reached.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

[filelist.f]
rtl/ile_pkg.sv
rtl/ile_decode.sv
rtl/ile_store.sv
rtl/indexed_list_engine_core.sv
rtl/ile_checker.sv
tb/tb_top.sv
